[hdl/tli_pkg.sv]
// tli_pkg: shared types and constants for the table linear interpolator
// used by tli_divider and table_linear_interpolator; no dependencies
package tli_pkg;

  localparam int unsigned DATA_W     = 32;
  localparam int unsigned PROD_W     = 2 * DATA_W;
  localparam int unsigned DIV_STEPS  = DATA_W;
  localparam int unsigned DIV_STEP_W = $clog2(DIV_STEPS);
  localparam int unsigned MIN_POINTS = 2;

  localparam logic OP_APPEND = 1'b0;
  localparam logic OP_QUERY  = 1'b1;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_ORDER = 2'd2;
  localparam logic [1:0] ST_FEW   = 2'd3;

  typedef struct packed {
    logic              start;
    logic [PROD_W-1:0] dividend;
    logic [DATA_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DATA_W-1:0] quotient;
  } div_rsp_t;

endpackage

[hdl/tli_divider.sv]
// tli_divider: serial restoring divider, one quotient bit per cycle
// dividend upper half must be below the divisor; depends on tli_pkg
module tli_divider (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  tli_pkg::div_req_t req_i,
  output tli_pkg::div_rsp_t rsp_o
);

  logic                                busy_q, busy_d;
  logic                                done_q, done_d;
  logic [tli_pkg::DIV_STEP_W-1:0]      step_q;
  logic [tli_pkg::DATA_W-1:0]          rem_q;
  logic [tli_pkg::DATA_W-1:0]          quo_q;
  logic [tli_pkg::DATA_W:0]            shifted;
  logic [tli_pkg::DATA_W:0]            diff;

  assign shifted = {rem_q, quo_q[tli_pkg::DATA_W-1]};
  assign diff    = shifted - {1'b0, req_i.divisor};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    if (req_i.start) begin
      busy_d = 1'b1;
    end else if (busy_q && step_q == tli_pkg::DIV_STEP_W'(tli_pkg::DIV_STEPS - 1)) begin
      busy_d = 1'b0;
      done_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      if (req_i.start) begin
        step_q <= '0;
      end else if (busy_q) begin
        step_q <= step_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= req_i.dividend[tli_pkg::PROD_W-1:tli_pkg::DATA_W];
      quo_q <= req_i.dividend[tli_pkg::DATA_W-1:0];
    end else if (busy_q) begin
      if (!diff[tli_pkg::DATA_W]) begin
        rem_q <= diff[tli_pkg::DATA_W-1:0];
        quo_q <= {quo_q[tli_pkg::DATA_W-2:0], 1'b1};
      end else begin
        rem_q <= shifted[tli_pkg::DATA_W-1:0];
        quo_q <= {quo_q[tli_pkg::DATA_W-2:0], 1'b0};
      end
    end
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

[hdl/table_linear_interpolator.sv]
// table_linear_interpolator: breakpoint table with piecewise linear lookup
// top level with sequencer and table memory; depends on tli_pkg, tli_divider
//
// usage
//   input stream: tuser bit 0 selects append (0) or query (1), bit 1 restarts
//   the table on append; tdata carries x (bits 31:0) and y (bits 63:32).
//   output stream: one result per request, value in tdata, status in tuser.
//   an append, or a query on n points clamped at the table ends, goes
//   straight to the result. a query inside the table runs a binary search
//   of up to P = ceil(log2(n+1)) probes, each a read then a compare (one
//   memory read port), then a multiply and the serial divider.
//   the block takes one request at a time; s_axis_tready is high when idle.
//   a finished result sits in the output register; a new request is taken
//   while it waits, and the next result is held back until the receiver
//   takes the pending one.
//   reset empties the table and clears the output; table memory is not
//   cleared, only entries below the point count are read.
module table_linear_interpolator #(
  parameter int unsigned TABLE_DEPTH = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // x[31:0], y[63:32]
  input  logic [1:0]  s_axis_tuser,   // op[0], restart[1]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // value[31:0]
  output logic [1:0]  m_axis_tuser    // status[1:0]
);

  localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned IDX_W = $clog2(TABLE_DEPTH);
  localparam int unsigned DW    = tli_pkg::DATA_W;

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_PROBE    = 4'd1;
  localparam logic [3:0] S_CMP      = 4'd2;
  localparam logic [3:0] S_FETCH_HI = 4'd3;
  localparam logic [3:0] S_FETCH_LO = 4'd4;
  localparam logic [3:0] S_MUL      = 4'd5;
  localparam logic [3:0] S_DIV_GO   = 4'd6;
  localparam logic [3:0] S_DIV_WAIT = 4'd7;
  localparam logic [3:0] S_DONE     = 4'd8;

  logic [3:0]       state_q, state_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [CNT_W-1:0] lo_q, lo_d;
  logic [CNT_W-1:0] hi_q, hi_d;
  logic             out_valid_q, out_valid_d;

  logic [CNT_W-1:0] mid_q, mid, hi_m1, cnt_eff;
  logic [DW-1:0]    first_x_q, first_y_q, last_x_q, last_y_q;
  logic [DW-1:0]    q_q, xhi_q, yhi_q, dx_q, span_q, ady_q, ylo_q;
  logic             neg_q;
  logic [tli_pkg::PROD_W-1:0] mag_q;
  logic [DW-1:0]    res_value_q, res_value_d;
  logic [1:0]       res_status_q, res_status_d;
  logic             res_we;
  logic [DW-1:0]    out_value_q;
  logic [1:0]       out_status_q;

  logic [2*DW-1:0]  mem [TABLE_DEPTH];
  logic [2*DW-1:0]  rd_q;
  logic [IDX_W-1:0] rd_addr;
  logic             mem_we;

  logic             in_fire, load_out;
  logic             in_op, in_restart;
  logic [DW-1:0]    in_x, in_y;
  logic             append_full, append_order;
  logic [DW:0]      dx_w, span_w, dy_w, ady_w;

  tli_pkg::div_req_t div_req;
  tli_pkg::div_rsp_t div_rsp;

  assign in_op      = s_axis_tuser[0];
  assign in_restart = s_axis_tuser[1];
  assign in_x       = s_axis_tdata[DW-1:0];
  assign in_y       = s_axis_tdata[2*DW-1:DW];
  assign in_fire    = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == S_IDLE);

  assign cnt_eff      = in_restart ? '0 : count_q;
  assign append_full  = (cnt_eff == CNT_W'(TABLE_DEPTH));
  assign append_order = (cnt_eff != '0) && ($signed(in_x) < $signed(last_x_q));

  assign mid   = lo_q + ((hi_q - lo_q) >> 1);
  assign hi_m1 = hi_q - 1'b1;

  // differences taken one bit wider, magnitudes fit the data width
  assign dx_w   = {q_q[DW-1], q_q} - {rd_q[DW-1], rd_q[DW-1:0]};
  assign span_w = {xhi_q[DW-1], xhi_q} - {rd_q[DW-1], rd_q[DW-1:0]};
  assign dy_w   = {yhi_q[DW-1], yhi_q} - {rd_q[2*DW-1], rd_q[2*DW-1:DW]};
  assign ady_w  = dy_w[DW] ? (~dy_w + 1'b1) : dy_w;

  assign div_req.start    = (state_q == S_DIV_GO);
  assign div_req.dividend = mag_q;
  assign div_req.divisor  = span_q;

  tli_divider u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    lo_d         = lo_q;
    hi_d         = hi_q;
    rd_addr      = '0;
    mem_we       = 1'b0;
    load_out     = 1'b0;
    res_we       = 1'b0;
    res_value_d  = '0;
    res_status_d = tli_pkg::ST_OK;
    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          if (in_op == tli_pkg::OP_APPEND) begin
            state_d = S_DONE;
            res_we  = 1'b1;
            if (append_full) begin
              res_status_d = tli_pkg::ST_FULL;
            end else if (append_order) begin
              res_status_d = tli_pkg::ST_ORDER;
            end else begin
              mem_we  = 1'b1;
              count_d = cnt_eff + 1'b1;
            end
          end else if (count_q < CNT_W'(tli_pkg::MIN_POINTS)) begin
            state_d      = S_DONE;
            res_we       = 1'b1;
            res_status_d = tli_pkg::ST_FEW;
          end else if ($signed(in_x) <= $signed(first_x_q)) begin
            state_d     = S_DONE;
            res_we      = 1'b1;
            res_value_d = first_y_q;
          end else if ($signed(in_x) >= $signed(last_x_q)) begin
            state_d     = S_DONE;
            res_we      = 1'b1;
            res_value_d = last_y_q;
          end else begin
            state_d = S_PROBE;
            lo_d    = '0;
            hi_d    = count_q;
          end
        end
      end
      S_PROBE: begin
        if (lo_q < hi_q) begin
          rd_addr = mid[IDX_W-1:0];
          state_d = S_CMP;
        end else begin
          rd_addr = hi_q[IDX_W-1:0];
          state_d = S_FETCH_HI;
        end
      end
      S_CMP: begin
        if ($signed(rd_q[DW-1:0]) > $signed(q_q)) begin
          hi_d = mid_q;
        end else begin
          lo_d = mid_q + 1'b1;
        end
        state_d = S_PROBE;
      end
      S_FETCH_HI: begin
        rd_addr = hi_m1[IDX_W-1:0];
        state_d = S_FETCH_LO;
      end
      S_FETCH_LO: state_d = S_MUL;
      S_MUL:      state_d = S_DIV_GO;
      S_DIV_GO:   state_d = S_DIV_WAIT;
      S_DIV_WAIT: begin
        if (div_rsp.done) begin
          state_d     = S_DONE;
          res_we      = 1'b1;
          res_value_d = neg_q ? (ylo_q - div_rsp.quotient) : (ylo_q + div_rsp.quotient);
        end
      end
      S_DONE: begin
        if (!out_valid_q || m_axis_tready) begin
          load_out = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      lo_q        <= '0;
      hi_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      lo_q        <= lo_d;
      hi_q        <= hi_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      q_q <= in_x;
    end
    if (mem_we) begin
      last_x_q <= in_x;
      last_y_q <= in_y;
      if (cnt_eff == '0) begin
        first_x_q <= in_x;
        first_y_q <= in_y;
      end
    end
    if (state_q == S_PROBE) begin
      mid_q <= mid;
    end
    if (state_q == S_FETCH_HI) begin
      xhi_q <= rd_q[DW-1:0];
      yhi_q <= rd_q[2*DW-1:DW];
    end
    if (state_q == S_FETCH_LO) begin
      dx_q   <= dx_w[DW-1:0];
      span_q <= span_w[DW-1:0];
      ady_q  <= ady_w[DW-1:0];
      neg_q  <= dy_w[DW];
      ylo_q  <= rd_q[2*DW-1:DW];
    end
    if (state_q == S_MUL) begin
      mag_q <= dx_q * ady_q;
    end
    if (res_we) begin
      res_value_q  <= res_value_d;
      res_status_q <= res_status_d;
    end
    if (load_out) begin
      out_value_q  <= res_value_q;
      out_status_q <= res_status_q;
    end
  end

  // table memory, one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[cnt_eff[IDX_W-1:0]] <= {in_y, in_x};
    end
    rd_q <= mem[rd_addr];
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_value_q;
  assign m_axis_tuser  = out_status_q;

endmodule
